[sv/multi_tone_sine_mixer_assert.svh]
// Assertion macros for the tone mixer checker.
// Depends on nothing; included by the checker file only.
`ifndef MULTI_TONE_SINE_MIXER_ASSERT_SVH
`define MULTI_TONE_SINE_MIXER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define MTSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mixer check failed");
// next-cycle implication
`define MTSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mixer check failed");
`endif

[sv/mtsm_pkg.sv]
// Shared types and constants for the multi-tone sine mixer.
// No dependencies.
`timescale 1ns / 1ps
package mtsm_pkg;
	localparam int unsigned IN_BITS = 104;
	localparam int unsigned OUT_BITS = 40;
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef struct packed {
		logic [23:0] dur;
		logic [23:0] start;
		logic [15:0] vol;
		logic [31:0] step;
	} tone_t;

	// request handed from the front to the back
	typedef struct packed {
		logic       op;
		logic [3:0] idx;
		tone_t      tone;
	} req_t;

	typedef struct packed {
		logic       finished;
		logic [2:0] active;
		logic [15:0] right;
		logic [15:0] left;
	} res_t;

	// restoring division of a nonnegative value below 2^48, used at elaboration only
	function automatic longint udiv_const(input longint num, input longint den);
		longint q;
		longint r;
		q = 0;
		r = 0;
		for (int b = 47; b >= 0; b--) begin
			r = (r <<< 1) | ((num >>> b) & 64'sd1);
			q = q <<< 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'sd1;
			end
		end
		return q;
	endfunction

	// quarter-wave sine in Q0.16, generated with the same Q30 Taylor series
	function automatic logic [15:0] qsine(input int unsigned i, input int unsigned bits);
		longint x;
		longint term;
		longint sum;
		longint e;
		x = (64'sd1686629713 * longint'(i)) >>> bits;
		term = x;
		sum = x;
		for (int k = 1; k <= 8; k++) begin
			term = (term * x) >>> 30;
			term = (term * x) >>> 30;
			term = udiv_const(term, longint'((2 * k) * (2 * k + 1)));
			if ((k & 1) == 1) sum = sum - term;
			else sum = sum + term;
		end
		if (sum < 0) sum = 0;
		e = (sum * 65536 + (64'sd1 <<< 29)) >>> 30;
		if (e > 65535) e = 65535;
		return e[15:0];
	endfunction
endpackage

[sv/mtsm_front.sv]
// Front end: takes input requests into a two-entry queue.
// Depends on mtsm_pkg.
`timescale 1ns / 1ps
module mtsm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mtsm_pkg::req_t     in_req,
	output logic               q_valid,
	input  logic               q_ready,
	output mtsm_pkg::req_t     q_req
);
	import mtsm_pkg::*;
	req_t     mem_q [2];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[sv/mtsm_back.sv]
// Back end: walks the tone table one tone per step and builds the mix.
// Depends on mtsm_pkg.
`timescale 1ns / 1ps
module mtsm_back #(
	parameter int NUM_TONES = 4,
	parameter int SINE_TABLE_BITS = 10,
	parameter int COUNT_BITS = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  mtsm_pkg::req_t q_req,
	output logic           out_valid,
	input  logic           out_ready,
	output mtsm_pkg::res_t out_res
);
	import mtsm_pkg::*;
	localparam int TB = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
	localparam int TAB_LEN = (1 << SINE_TABLE_BITS) + 1;
	localparam int AB = $clog2(NUM_TONES + 1);
	localparam int ROM_BITS = TAB_LEN * 16;

	// quarter-wave table, one 16-bit entry per index, entry 0 in the lowest bits
	function automatic logic [ROM_BITS-1:0] build_rom();
		logic [ROM_BITS-1:0] rom;
		rom = '0;
		for (int i = 0; i < TAB_LEN; i++)
			rom[i*16 +: 16] = qsine(unsigned'(i), unsigned'(SINE_TABLE_BITS));
		return rom;
	endfunction

	localparam logic [ROM_BITS-1:0] SINE_ROM = build_rom();

	typedef enum logic [2:0] {
		S_IDLE, S_PHASE, S_SINE, S_MAG, S_NEXT, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	tone_t tone_q [NUM_TONES];
	logic [NUM_TONES-1:0] loaded_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [TB-1:0] ti_q;
	logic [31:0] phase_q;
	logic [15:0] sin_q;
	logic [1:0]  quad_q;
	logic [63:0] prod_q;
	logic        win_q;
	logic signed [16:0] val_q [NUM_TONES];
	logic [AB-1:0] act_q;
	logic          done_q;
	logic signed [16:0] mix_q;
	logic [TB-1:0] di_q;
	// serial divider state
	logic [15:0] dq_q, dr_q;
	logic [4:0]  dbit_q;
	logic        div_run_q;
	res_t res_q;
	logic out_valid_q;

	tone_t cur;
	logic [24:0] end_c;
	logic [31:0] diff_c;
	logic [SINE_TABLE_BITS-1:0] idx_c;
	logic [SINE_TABLE_BITS:0]   tidx_c;
	logic [16:0] mag_c;
	logic [16:0] rem_c;
	logic [15:0] absv_c;
	logic signed [16:0] quo_c;
	logic [2:0] act_sat;

	assign cur = loaded_q[ti_q] ? tone_q[ti_q] : '0;
	assign end_c = {1'b0, cur.start} + {1'b0, cur.dur};
	assign diff_c = 32'(cnt_q) - 32'(cur.start);
	assign idx_c = phase_q[29 -: SINE_TABLE_BITS];
	assign tidx_c = phase_q[30] ? ((SINE_TABLE_BITS+1)'(1 << SINE_TABLE_BITS)
		- {1'b0, idx_c}) : {1'b0, idx_c};
	assign mag_c = (prod_q[63:31] > 33'd32767) ? 17'd32767 : prod_q[47:31];
	assign absv_c = val_q[di_q][16] ? 16'(-val_q[di_q]) : val_q[di_q][15:0];
	assign rem_c = {dr_q, dq_q[15]} ;
	assign quo_c = val_q[di_q][16] ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
	assign act_sat = (act_q > AB'(7)) ? 3'd7 : 3'(act_q);

	assign q_ready = (state_q == S_IDLE) && !(q_req.op == OP_TICK && out_valid_q && !out_ready);
	assign out_valid = out_valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid && q_req.op == OP_LOAD
			&& {1'b0, q_req.idx} < 5'(NUM_TONES))
			tone_q[q_req.idx[TB-1:0]] <= q_req.tone;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loaded_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			ti_q <= '0;
			di_q <= '0;
			act_q <= '0;
			done_q <= 1'b0;
			div_run_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_ready) begin
						if (q_req.op == OP_LOAD) begin
							if ({1'b0, q_req.idx} < 5'(NUM_TONES))
								loaded_q[q_req.idx[TB-1:0]] <= 1'b1;
						end else begin
							ti_q <= '0;
							act_q <= '0;
							done_q <= 1'b1;
							state_q <= S_PHASE;
						end
					end
				end
				S_PHASE: begin
					phase_q <= diff_c * cur.step;
					win_q <= ({1'b0, cnt_q} >= (COUNT_BITS+1)'(cur.start))
						&& (33'(cnt_q) < 33'(end_c));
					if (33'(cnt_q) < 33'(end_c)) done_q <= 1'b0;
					state_q <= S_SINE;
				end
				S_SINE: begin
					sin_q <= SINE_ROM[{tidx_c, 4'd0} +: 16];
					quad_q <= phase_q[31:30];
					state_q <= S_MAG;
				end
				S_MAG: begin
					prod_q <= 64'(sin_q) * 64'(32767) * 64'(cur.vol);
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (win_q && mag_c != 0) begin
						val_q[ti_q] <= quad_q[1] ? -$signed(mag_c) : $signed(mag_c);
						act_q <= act_q + AB'(1);
					end else begin
						val_q[ti_q] <= '0;
					end
					if (ti_q == TB'(NUM_TONES - 1)) begin
						di_q <= '0;
						mix_q <= '0;
						div_run_q <= 1'b0;
						state_q <= S_DIV;
					end else begin
						ti_q <= ti_q + TB'(1);
						state_q <= S_PHASE;
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit per cycle
					if (!div_run_q) begin
						dq_q <= absv_c;
						dr_q <= '0;
						dbit_q <= 5'd16;
						div_run_q <= (act_q != '0);
						if (act_q == '0) state_q <= S_OUT;
					end else if (dbit_q != 0) begin
						if (rem_c >= 17'(act_q)) begin
							dr_q <= 16'(rem_c - 17'(act_q));
							dq_q <= {dq_q[14:0], 1'b1};
						end else begin
							dr_q <= rem_c[15:0];
							dq_q <= {dq_q[14:0], 1'b0};
						end
						dbit_q <= dbit_q - 5'd1;
					end else begin
						mix_q <= mix_q + quo_c;
						div_run_q <= 1'b0;
						if (di_q == TB'(NUM_TONES - 1)) state_q <= S_OUT;
						else di_q <= di_q + TB'(1);
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						res_q.left <= mix_q[15:0];
						res_q.right <= 16'(-mix_q);
						res_q.active <= act_sat;
						res_q.finished <= done_q;
						out_valid_q <= 1'b1;
						cnt_q <= cnt_q + COUNT_BITS'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/multi_tone_sine_mixer.sv]
// channel   | group         | contents
// input     | s_axis_*      | tdata {duration, start, volume, phase_step, tone_index}, tuser op
// output    | m_axis_*      | tdata {finished, active_tones, right, left}
// A load is taken by the back end while idle; a tick walks each tone through the phase,
// sine, magnitude and store steps, then divides each tone's value serially by the active
// count when any tone sounds, and ends in the output step. The queue registers requests.
// A two-entry queue lets input be taken while the back end works; a tick waits there
// while the previous sample is not taken.
// arst_n clears the tone table to silent and the sample counter to zero.
// Top level: depends on mtsm_pkg, mtsm_front, mtsm_back.
`timescale 1ns / 1ps
module multi_tone_sine_mixer #(
	parameter int NUM_TONES = 4,
	parameter int SINE_TABLE_BITS = 10,
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tone_index[1:0], phase_step[33:2], tone_volume[49:34], start[73:50], duration[97:74]
	input  logic [103:0] s_axis_tdata,
	// op
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// left[15:0], right[31:16], active_tones[34:32], finished[35]
	output logic [39:0] m_axis_tdata
);
	import mtsm_pkg::*;
	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_ready;

	assign in_req.op = s_axis_tuser;
	assign in_req.idx = {2'b00, s_axis_tdata[1:0]};
	assign in_req.tone.step = s_axis_tdata[33:2];
	assign in_req.tone.vol = s_axis_tdata[49:34];
	assign in_req.tone.start = s_axis_tdata[73:50];
	assign in_req.tone.dur = s_axis_tdata[97:74];
	assign m_axis_tdata = {4'b0, res};

	mtsm_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req,
		.q_valid, .q_ready, .q_req
	);

	mtsm_back #(
		.NUM_TONES(NUM_TONES), .SINE_TABLE_BITS(SINE_TABLE_BITS), .COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_req,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);
endmodule

[sv/mtsm_checker.sv]
// Port-level checks for the tone mixer, bound to the top level.
// Depends on multi_tone_sine_mixer_assert.svh.
`timescale 1ns / 1ps
`include "multi_tone_sine_mixer_assert.svh"
module mtsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	`MTSM_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`MTSM_ASSERT_IMP(a_neg, clk, arst_n, m_axis_tvalid, m_axis_tdata[31:16] == 16'(-m_axis_tdata[15:0]))
	`MTSM_ASSERT_IMP(a_act, clk, arst_n, m_axis_tvalid && m_axis_tdata[34:32] == 3'd0, m_axis_tdata[15:0] == 16'd0)
	`MTSM_ASSERT_IMP(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[39:36] == 4'd0)
endmodule

bind multi_tone_sine_mixer mtsm_checker u_mtsm_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the multi-tone sine mixer: directed and random requests.
// It predicts each tick's stereo sample and compares it with the output stream.
// Depends on mtsm_pkg and the multi_tone_sine_mixer RTL.
`timescale 1ns / 1ps
module testbench;
	import mtsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [39:0]  m_axis_tdata;

	// predictor state
	tone_t       tones [4];
	logic [23:0] sample_count;
	logic [15:0] sine_lut [0:1024];
	res_t        sample_queue [$];

	int errors = 0;
	int idle_count = 0;
	int sink_hold = 0;
	bit send_idle = 1'b1;
	bit sink_idle = 1'b1;

	multi_tone_sine_mixer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// quarter-wave sine entry in Q0.16, odd Taylor terms in Q30
	function automatic logic [15:0] sine_entry(input int i);
		longint x;
		longint term;
		longint acc;
		longint q16;
		x = (64'sd1686629713 * longint'(i)) >>> 10;
		term = x;
		acc = x;
		for (int k = 1; k <= 8; k++) begin
			term = (term * x) >>> 30;
			term = (term * x) >>> 30;
			term = term / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) acc = acc - term;
			else acc = acc + term;
		end
		if (acc < 0) acc = 0;
		q16 = (acc * 65536 + (64'sd1 <<< 29)) >>> 30;
		if (q16 > 65535) q16 = 65535;
		return q16[15:0];
	endfunction

	function automatic int tone_level(input tone_t t, input logic [23:0] n);
		logic [31:0] phase;
		logic [10:0] idx;
		longint mag;
		phase = ({8'd0, n} - {8'd0, t.start}) * t.step;
		idx = {1'b0, phase[29:20]};
		if (phase[30]) idx = 11'd1024 - idx;
		mag = (longint'(sine_lut[idx]) * 32767 * longint'(t.vol)) >>> 31;
		if (mag > 32767) mag = 32767;
		return phase[31] ? -int'(mag) : int'(mag);
	endfunction

	function automatic res_t mix_sample();
		int vals [4];
		int active;
		int mix;
		logic [24:0] stop;
		bit done;
		res_t r;
		active = 0;
		mix = 0;
		done = 1'b1;
		for (int i = 0; i < 4; i++) begin
			stop = {1'b0, tones[i].start} + {1'b0, tones[i].dur};
			vals[i] = 0;
			if ({1'b0, sample_count} < stop) begin
				done = 1'b0;
				if (sample_count >= tones[i].start) vals[i] = tone_level(tones[i], sample_count);
			end
			if (vals[i] != 0) active++;
		end
		if (active > 0)
			for (int i = 0; i < 4; i++) mix += vals[i] / active;
		r.left = mix[15:0];
		r.right = 16'(-mix);
		r.active = active[2:0];
		r.finished = done;
		sample_count = sample_count + 24'd1;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// send one request; a tick queues its predicted sample
	task automatic send_request(input logic op, input logic [1:0] idx, input logic [31:0] step,
			input logic [15:0] vol, input logic [23:0] start, input logic [23:0] dur);
		int gap;
		bit taken;
		gap = send_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, dur, start, vol, step, idx};
		do begin
			@(negedge clk);
			taken = s_axis_tready;
			@(posedge clk);
		end while (!taken);
		if (op == OP_LOAD) begin
			tones[idx].step = step;
			tones[idx].vol = vol;
			tones[idx].start = start;
			tones[idx].dur = dur;
		end else begin
			sample_queue.insert(sample_queue.size(), mix_sample());
		end
	endtask

	task automatic tick();
		send_request(OP_TICK, 2'd0, 32'd0, 16'd0, 24'd0, 24'd0);
	endtask

	task automatic load(input logic [1:0] idx, input logic [31:0] step, input logic [15:0] vol,
			input logic [23:0] start, input logic [23:0] dur);
		send_request(OP_LOAD, idx, step, vol, start, dur);
	endtask

	// result checker: the handshake completes at the next rising edge
	always @(negedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[35:0];
			if (sample_queue.size() == 0) begin
				report_mismatch("unexpected sample", int'(got.left), 0);
			end else begin
				want = sample_queue.pop_front();
				if (got.left !== want.left)
					report_mismatch("left", int'($signed(got.left)), int'($signed(want.left)));
				if (got.right !== want.right)
					report_mismatch("right", int'($signed(got.right)), int'($signed(want.right)));
				if (got.active !== want.active)
					report_mismatch("active_tones", int'(got.active), int'(want.active));
				if (got.finished !== want.finished)
					report_mismatch("finished", int'(got.finished), int'(want.finished));
			end
		end
	end

	// watchdog: cycles with no request moving on either side
	always @(negedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_count = 0;
		end else begin
			idle_count++;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: random stalls, or a long hold-off on request
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			if (sink_hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			m_axis_tready <= 1'b1;
			run = $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			if (sink_idle && sink_hold == 0) begin
				run = pick_gap();
				if (run > 0) begin
					m_axis_tready <= 1'b0;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	task automatic test_silent_table();
		for (int i = 0; i < 3; i++) tick();
	endtask

	task automatic test_extremes();
		// quarter-turn steps walk all four quadrants at full scale
		load(2'd0, 32'h4000_0000, 16'd32768, sample_count, 24'd6);
		load(2'd1, 32'h0123_4567, 16'd0, sample_count, 24'd6);
		for (int i = 0; i < 5; i++) tick();
		// volume above full scale saturates
		load(2'd2, 32'hFFFF_FFFF, 16'hFFFF, sample_count, 24'hFFFFFF);
		load(2'd3, 32'h1000_0001, 16'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
		for (int i = 0; i < 4; i++) tick();
		// zero duration and a zero step
		load(2'd2, 32'd0, 16'd32768, sample_count, 24'd0);
		load(2'd3, 32'd0, 16'd32768, sample_count, 24'd2);
		for (int i = 0; i < 3; i++) tick();
	endtask

	task automatic test_windows();
		load(2'd0, 32'h0800_0000, 16'd20000, sample_count + 24'd2, 24'd3);
		load(2'd2, 32'h0300_0000, 16'd30000, sample_count + 24'd1, 24'd2);
		for (int i = 0; i < 7; i++) tick();
	endtask

	task automatic random_items(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 75) begin
				tick();
			end else if ($urandom_range(0, 99) < 80) begin
				load(2'($urandom_range(0, 3)), $urandom(),
					($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768)),
					sample_count + 24'($urandom_range(0, 20)), 24'($urandom_range(1, 60)));
			end else begin
				load(2'($urandom()), $urandom(), 16'($urandom()), 24'($urandom()), 24'($urandom()));
			end
		end
	endtask

	task automatic test_random();
		random_items(800);
		send_idle = 1'b0;
		sink_idle = 1'b0;
		random_items(300);
		send_idle = 1'b1;
		sink_idle = 1'b1;
		random_items(700);
	endtask

	task automatic test_backpressure();
		sink_hold = 1500;
		for (int i = 0; i < 4; i++)
			load(2'(i), $urandom(), 16'($urandom_range(0, 32768)), sample_count, 24'd40);
		for (int i = 0; i < 30; i++) tick();
	endtask

	initial begin
		for (int i = 0; i <= 1024; i++) sine_lut[i] = sine_entry(i);
		for (int i = 0; i < 4; i++) tones[i] = '0;
		sample_count = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_silent_table();
		test_extremes();
		test_windows();
		test_backpressure();
		test_random();
		s_axis_tvalid <= 1'b0;
		while (sample_queue.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/mtsm_pkg.sv
sv/mtsm_front.sv
sv/mtsm_back.sv
sv/multi_tone_sine_mixer.sv
sv/mtsm_checker.sv
tb/sv/testbench.sv
